// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear interpolator package
// Widths, codes and the control bundle shared by the interpolator modules.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int DATA_W     = 32;
   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int COUNT_W    = 7;
   localparam int FRAC_W     = 16;
   localparam int SPAN_W     = DATA_W + 1;
   localparam int QUO_W      = SPAN_W + FRAC_W;
   localparam int ACC_W      = QUO_W + 1;
   localparam int STEP_W     = 6;
   localparam int DIV_STEPS  = QUO_W;
   localparam int MUL_STEPS  = DATA_W;
   localparam int REGION_W   = 2;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [REGION_W-1:0] REGION_INSIDE = 2'd0;
   localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

   typedef struct packed {
      logic start;
      logic op_mul;
   } pli_cmd_type;

endpackage

// ===== rtl/pli_muldiv.sv =====
// ----------------------------------------------------------------------------
// Interpolator multiply/divide unit
// Radix-2 unsigned divider and shift-add multiplier around one shared adder.
// ----------------------------------------------------------------------------
module pli_muldiv (
   input  logic                        clock,
   input  logic                        reset,
   input  pli_pkg::pli_cmd_type        cmd,
   input  logic [pli_pkg::QUO_W-1:0]   opa,
   input  logic [pli_pkg::SPAN_W-1:0]  opb,
   output logic [pli_pkg::QUO_W-1:0]   res_hi,
   output logic [pli_pkg::QUO_W-1:0]   res_lo,
   output logic                        done
);
   import pli_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              mul_ff, mul_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [QUO_W-1:0]  lo_ff, lo_in;
   logic [QUO_W-1:0]  opb_ff, opb_in;

   logic [SPAN_W:0]   rem_shift;
   logic [ACC_W-1:0]  add_a;
   logic [ACC_W-1:0]  add_b;
   logic [ACC_W-1:0]  add_sum;

   assign rem_shift = {acc_ff[SPAN_W-1:0], lo_ff[QUO_W-1]};

   always_comb begin
      if (mul_ff) begin
         add_a = {1'b0, acc_ff[QUO_W-1:0]};
         add_b = lo_ff[0] ? {1'b0, opb_ff} : '0;
      end else begin
         add_a = {{(ACC_W-SPAN_W-1){1'b0}}, rem_shift};
         add_b = ~{1'b0, opb_ff};
      end
      add_sum = add_a + add_b + {{(ACC_W-1){1'b0}}, ~mul_ff};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      opb_in  = opb_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         mul_in = cmd.op_mul;
         acc_in = '0;
         if (cmd.op_mul) begin
            cnt_in = STEP_W'(MUL_STEPS - 1);
            lo_in  = {{(QUO_W-DATA_W){1'b0}}, opb[DATA_W-1:0]};
            opb_in = opa;
         end else begin
            cnt_in = STEP_W'(DIV_STEPS - 1);
            lo_in  = opa;
            opb_in = {{(QUO_W-SPAN_W){1'b0}}, opb};
         end
      end else if (run_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         if (mul_ff) begin
            acc_in = {1'b0, add_sum[ACC_W-1:1]};
            lo_in  = {add_sum[0], lo_ff[QUO_W-1:1]};
         end else if (!add_sum[ACC_W-1]) begin
            acc_in = add_sum;
            lo_in  = {lo_ff[QUO_W-2:0], 1'b1};
         end else begin
            acc_in = {{(ACC_W-SPAN_W-1){1'b0}}, rem_shift};
            lo_in  = {lo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mul_ff <= mul_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      opb_ff <= opb_in;
   end

   assign res_hi = acc_ff[QUO_W-1:0];
   assign res_lo = lo_ff;
   assign done   = done_ff;

endmodule

// ===== rtl/piecewise_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear interpolator
// Clamped linear interpolation over a table of signed Q16.16 breakpoints.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_*                      start high, busy low
//   response  rsp_valid, rsp_y_result, rsp_region    rsp_valid high, 1 cycle
//   csr       csr_we, csr_wdata (point_count)        csr_we high
//
// A breakpoint write is taken in ST_IDLE without leaving it. A query below or
// above the table ends in ST_CHK_LO or ST_CHK_HI. An interior query runs a
// linear scan over the points in use, reading one table entry per cycle, then
// 49 divide steps and 32 multiply steps on the shared adder.
// Reset is synchronous and sets point_count to 2; the table is not cleared.
// The receiver cannot stall; each response is shown for one cycle.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [pli_pkg::ADDR_W-1:0]    req_point_index,
   input  logic signed [pli_pkg::DATA_W-1:0] req_x_coord,
   input  logic signed [pli_pkg::DATA_W-1:0] req_y_coord,
   output logic                          rsp_valid,
   output logic signed [pli_pkg::DATA_W-1:0] rsp_y_result,
   output logic [pli_pkg::REGION_W-1:0]  rsp_region,
   input  logic                          csr_we,
   input  logic [pli_pkg::COUNT_W-1:0]   csr_wdata
);
   import pli_pkg::*;

   localparam int SUM_W = DATA_W + 4;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (DATA_W-1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHK_LO, ST_CHK_HI, ST_SCAN, ST_FETCH_I, ST_FETCH_J,
      ST_DIVIDE, ST_MULTIPLY
   } state_type;

   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff;
   logic [2*DATA_W-1:0]       mem_ff [MAX_POINTS];
   logic [2*DATA_W-1:0]       rd_ff;
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic [ADDR_W-1:0]         nl_ff, nl_in;
   logic [ADDR_W-1:0]         k_ff, k_in;
   logic [ADDR_W-1:0]         i_ff, i_in;
   logic signed [DATA_W-1:0]  xi_ff, xi_in;
   logic signed [DATA_W-1:0]  yi_ff, yi_in;
   logic                      neg_ff, neg_in;
   logic [DATA_W-1:0]         offm_ff, offm_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_y_ff, rsp_y_in;
   logic [REGION_W-1:0]       rsp_region_ff, rsp_region_in;

   logic                      mem_we;
   logic [ADDR_W-1:0]         raddr;
   logic signed [DATA_W-1:0]  rd_x, rd_y;
   logic [ADDR_W-1:0]         i_next;
   logic [ADDR_W-1:0]         n_last;
   logic signed [SPAN_W-1:0]  dx, dy, off;
   logic [SPAN_W-1:0]         dx_mag, dy_mag, off_mag;
   logic [SUM_W-1:0]          mag_low;
   logic signed [SUM_W-1:0]   sum;
   logic signed [DATA_W-1:0]  y_final;
   pli_cmd_type               cmd;
   logic [QUO_W-1:0]          md_opa;
   logic [SPAN_W-1:0]         md_opb;
   logic [QUO_W-1:0]          md_hi, md_lo;
   logic                      md_done;

   pli_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .opa    (md_opa),
      .opb    (md_opb),
      .res_hi (md_hi),
      .res_lo (md_lo),
      .done   (md_done)
   );

   assign rd_x = rd_ff[2*DATA_W-1:DATA_W];
   assign rd_y = rd_ff[DATA_W-1:0];

   assign dx      = {rd_x[DATA_W-1], rd_x} - {xi_ff[DATA_W-1], xi_ff};
   assign dy      = {rd_y[DATA_W-1], rd_y} - {yi_ff[DATA_W-1], yi_ff};
   assign off     = {x_ff[DATA_W-1], x_ff} - {xi_ff[DATA_W-1], xi_ff};
   assign dx_mag  = dx[SPAN_W-1] ? -dx : dx;
   assign dy_mag  = dy[SPAN_W-1] ? -dy : dy;
   assign off_mag = off[SPAN_W-1] ? -off : off;
   assign i_next  = (rd_x <= x_ff) ? k_ff : i_ff;

   always_comb begin
      if (count_ff < COUNT_W'(2)) begin
         n_last = ADDR_W'(1);
      end else if (count_ff > COUNT_W'(MAX_POINTS)) begin
         n_last = ADDR_W'(MAX_POINTS - 1);
      end else begin
         n_last = ADDR_W'(count_ff - 1'b1);
      end
   end

   always_comb begin
      mag_low = {2'b00, md_hi[DATA_W+2-FRAC_W-1:0], md_lo[QUO_W-1:QUO_W-FRAC_W]};
      sum     = neg_ff ? (SUM_W'(yi_ff) - $signed(mag_low))
                       : (SUM_W'(yi_ff) + $signed(mag_low));
      if (|md_hi[QUO_W-1:DATA_W+2-FRAC_W]) begin
         y_final = neg_ff ? DATA_W'(SAT_MIN) : DATA_W'(SAT_MAX);
      end else if (sum > SAT_MAX) begin
         y_final = DATA_W'(SAT_MAX);
      end else if (sum < SAT_MIN) begin
         y_final = DATA_W'(SAT_MIN);
      end else begin
         y_final = sum[DATA_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      nl_in         = nl_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      xi_in         = xi_ff;
      yi_in         = yi_ff;
      neg_in        = neg_ff;
      offm_in       = offm_ff;
      rsp_valid_in  = 1'b0;
      rsp_y_in      = rsp_y_ff;
      rsp_region_in = rsp_region_ff;
      mem_we        = 1'b0;
      raddr         = '0;
      cmd           = '0;
      md_opa        = {dy_mag, {FRAC_W{1'b0}}};
      md_opb        = dx_mag;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_type == REQ_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  x_in     = req_x_coord;
                  nl_in    = n_last;
                  state_in = ST_CHK_LO;
               end
            end
         end
         ST_CHK_LO: begin
            if (x_ff < rd_x) begin
               rsp_valid_in  = 1'b1;
               rsp_y_in      = rd_y;
               rsp_region_in = REGION_BELOW;
               state_in      = ST_IDLE;
            end else begin
               raddr    = nl_ff;
               state_in = ST_CHK_HI;
            end
         end
         ST_CHK_HI: begin
            if (x_ff > rd_x) begin
               rsp_valid_in  = 1'b1;
               rsp_y_in      = rd_y;
               rsp_region_in = REGION_ABOVE;
               state_in      = ST_IDLE;
            end else begin
               k_in     = '0;
               i_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            i_in = i_next;
            if (k_ff == nl_ff - 1'b1) begin
               raddr    = i_next;
               state_in = ST_FETCH_I;
            end else begin
               k_in  = k_ff + 1'b1;
               raddr = k_ff + 1'b1;
            end
         end
         ST_FETCH_I: begin
            xi_in    = rd_x;
            yi_in    = rd_y;
            raddr    = i_ff + 1'b1;
            state_in = ST_FETCH_J;
         end
         ST_FETCH_J: begin
            if (dx == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_y_in      = yi_ff;
               rsp_region_in = REGION_INSIDE;
               state_in      = ST_IDLE;
            end else begin
               cmd.start = 1'b1;
               neg_in    = dx[SPAN_W-1] ^ dy[SPAN_W-1] ^ off[SPAN_W-1];
               offm_in   = off_mag[DATA_W-1:0];
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            md_opa = md_lo;
            md_opb = {1'b0, offm_ff};
            if (md_done) begin
               cmd.start  = 1'b1;
               cmd.op_mul = 1'b1;
               state_in   = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            if (md_done) begin
               rsp_valid_in  = 1'b1;
               rsp_y_in      = y_final;
               rsp_region_in = REGION_INSIDE;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[req_point_index] <= {req_x_coord, req_y_coord};
      end
      rd_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_W'(2);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
      x_ff          <= x_in;
      nl_ff         <= nl_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      xi_ff         <= xi_in;
      yi_ff         <= yi_in;
      neg_ff        <= neg_in;
      offm_ff       <= offm_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_y_result = rsp_y_ff;
   assign rsp_region   = rsp_region_ff;

endmodule

// ===== test/tb_piecewise_linear_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// Piecewise-linear interpolator testbench
// Writes breakpoint tables, drives queries and point_count settings, including
// ones below and above the limits, and checks every result against an interpolation
// predictor kept in this file. Directed cases come first, then randomly
// filled tables under three sender idle levels.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_interpolator_unit;
   import pli_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] y_value;
      logic [REGION_W-1:0]      region;
   } interp_result_type;

   localparam longint unsigned PRODUCT_CAP = 64'd1 << 62;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;
   localparam logic signed [DATA_W-1:0] X_LOWEST  = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] X_HIGHEST = 32'sh7FFF_FFFF;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_type = REQ_WRITE;
   logic [ADDR_W-1:0]        req_point_index = '0;
   logic signed [DATA_W-1:0] req_x_coord = '0;
   logic signed [DATA_W-1:0] req_y_coord = '0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_y_result;
   logic [REGION_W-1:0]      rsp_region;
   logic                     csr_we = 1'b0;
   logic [COUNT_W-1:0]       csr_wdata = '0;

   logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
   logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
   logic [COUNT_W-1:0]       active_points = 7'd2;
   interp_result_type        pending_interp [$];

   int error_count = 0;
   int write_count = 0;
   int cfg_count = 0;
   int region_count [3] = '{0, 0, 0};
   int sender_idle_pct = 38;

   piecewise_linear_interpolator_unit DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_point_index(req_point_index),
      .req_x_coord(req_x_coord),
      .req_y_coord(req_y_coord),
      .rsp_valid(rsp_valid),
      .rsp_y_result(rsp_y_result),
      .rsp_region(rsp_region),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int effective_points();
      if (active_points < 2) return 2;
      if (active_points > MAX_POINTS) return MAX_POINTS;
      return int'(active_points);
   endfunction

   function automatic interp_result_type interpolate_at(input logic signed [DATA_W-1:0] qx);
      interp_result_type r;
      int n;
      int seg;
      longint x, x_lo, x_hi, y_lo, y_hi, span, rise, slope, off, value;
      longint unsigned slope_mag, off_mag, mag, mag_hi, mag_lo;
      n = effective_points();
      x = longint'(qx);
      if (x < longint'(bp_x[0])) begin
         value = longint'(bp_y[0]);
         r.region = REGION_BELOW;
      end else if (x > longint'(bp_x[n-1])) begin
         value = longint'(bp_y[n-1]);
         r.region = REGION_ABOVE;
      end else begin
         r.region = REGION_INSIDE;
         seg = 0;
         for (int k = 0; k + 1 < n; k++)
            if (longint'(bp_x[k]) <= x) seg = k;
         x_lo = longint'(bp_x[seg]);
         x_hi = longint'(bp_x[seg+1]);
         y_lo = longint'(bp_y[seg]);
         y_hi = longint'(bp_y[seg+1]);
         span = x_hi - x_lo;
         if (span == 0) begin
            value = y_lo;
         end else begin
            rise = y_hi - y_lo;
            slope = (rise * 65536) / span;
            off = x - x_lo;
            slope_mag = (slope < 0) ? -slope : slope;
            off_mag = (off < 0) ? -off : off;
            mag_hi = slope_mag >> FRAC_W;
            mag_lo = slope_mag & 64'hFFFF;
            if (off_mag != 0 && mag_hi > PRODUCT_CAP / off_mag) begin
               mag = PRODUCT_CAP;
            end else begin
               mag = mag_hi * off_mag + ((mag_lo * off_mag) >> FRAC_W);
               if (mag > PRODUCT_CAP) mag = PRODUCT_CAP;
            end
            if ((slope < 0) != (off < 0)) value = y_lo - longint'(mag);
            else value = y_lo + longint'(mag);
         end
      end
      if (value > VALUE_MAX) value = VALUE_MAX;
      if (value < VALUE_MIN) value = VALUE_MIN;
      r.y_value = value[DATA_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      if (error_count < 50)
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      interp_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_interp.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_y_result);
         end else begin
            want = pending_interp.pop_front();
            if (rsp_y_result !== want.y_value)
               report_mismatch("y_result", want.y_value, rsp_y_result);
            if (rsp_region !== want.region)
               report_mismatch("region", DATA_W'(want.region), DATA_W'(rsp_region));
         end
      end
   end

   task automatic send_item(input logic kind, input logic [ADDR_W-1:0] slot,
                            input logic signed [DATA_W-1:0] x,
                            input logic signed [DATA_W-1:0] y);
      int gap;
      interp_result_type result;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_point_index <= slot;
      req_x_coord <= x;
      req_y_coord <= y;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      if (kind == REQ_WRITE) begin
         bp_x[slot] = x;
         bp_y[slot] = y;
         write_count++;
      end else begin
         result = interpolate_at(x);
         region_count[result.region]++;
         pending_interp.push_back(result);
      end
   endtask

   // Breakpoint writes give no result, so busy is watched as well as the queue.
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_interp.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_point_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      active_points = value;
      cfg_count++;
      @(posedge clock);
   endtask

   // Fills slots 0 to n-1 with rising x values; an occasional repeated x gives
   // a zero span.
   task automatic load_sorted_table(input int n);
      longint max_step, slack, x;
      int scale;
      logic signed [DATA_W-1:0] y;
      scale = $urandom_range(2);
      max_step = (scale == 0) ? 16 : (scale == 1) ? 65536 : (64'd1 << 25);
      slack = 64'd4294967295 - n * max_step;
      x = VALUE_MIN + longint'($urandom_range(32'(slack)));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(1) == 0) y = $urandom;
         else y = $urandom_range(0, 1 << 20) - (1 << 19);
         send_item(REQ_WRITE, ADDR_W'(k), x[DATA_W-1:0], y);
         if ($urandom_range(19) != 0) x += $urandom_range(1, 32'(max_step));
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_query_x(input int n);
      longint lo, hi, x;
      longint unsigned span;
      int pick;
      lo = longint'(bp_x[0]);
      hi = longint'(bp_x[n-1]);
      pick = $urandom_range(99);
      if (pick < 50 && hi >= lo) begin
         span = hi - lo + 1;
         x = lo + longint'({$urandom, $urandom} % span);
      end else if (pick < 65) begin
         x = longint'(bp_x[$urandom_range(n-1)]);
      end else if (pick < 75) begin
         x = lo - $urandom_range(1, 65536);
      end else if (pick < 85) begin
         x = hi + $urandom_range(1, 65536);
      end else begin
         x = longint'($signed($urandom));
      end
      if (x < VALUE_MIN || x > VALUE_MAX) x = longint'($signed($urandom));
      return x[DATA_W-1:0];
   endfunction

   task automatic test_extreme_breakpoints();
      send_item(REQ_WRITE, 6'd0, X_LOWEST, X_HIGHEST);
      send_item(REQ_WRITE, 6'd1, X_HIGHEST, X_LOWEST);
      send_item(REQ_QUERY, 6'd0, X_LOWEST, '0);
      send_item(REQ_QUERY, 6'd0, X_HIGHEST, '0);
      send_item(REQ_QUERY, 6'd0, 32'sd0, '0);
      send_item(REQ_QUERY, 6'd63, 32'sh0000_3039, '1);
   endtask

   task automatic test_zero_span();
      send_item(REQ_WRITE, 6'd1, X_LOWEST, 32'sh0007_0000);
      send_item(REQ_QUERY, 6'd0, X_LOWEST, '0);
      send_item(REQ_QUERY, 6'd0, 32'sh0000_0001, '0);
   endtask

   task automatic test_region_clamps();
      send_item(REQ_WRITE, 6'd0, 32'sh0001_0000, -32'sh0002_0000);
      send_item(REQ_WRITE, 6'd1, 32'sh0003_0000, 32'sh0004_0000);
      send_item(REQ_QUERY, 6'd0, 32'sd0, '0);
      send_item(REQ_QUERY, 6'd0, 32'sh0002_0000, '0);
      send_item(REQ_QUERY, 6'd0, 32'sh0003_0000, '0);
      send_item(REQ_QUERY, 6'd0, X_HIGHEST, '0);
      send_item(REQ_QUERY, 6'd0, 32'sh0001_8000, '0);
      send_item(REQ_QUERY, 6'd0, X_LOWEST, '0);
   endtask

   // Counts below two and above the table size must behave as the nearest limit.
   task automatic test_point_count_limits();
      logic [COUNT_W-1:0] settings [6] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64, 7'd2};
      int n;
      load_sorted_table(MAX_POINTS);
      foreach (settings[s]) begin
         write_point_count(settings[s]);
         n = effective_points();
         send_item(REQ_QUERY, '0, bp_x[0], '0);
         send_item(REQ_QUERY, '0, bp_x[n-1], '0);
         send_item(REQ_QUERY, '0, bp_x[MAX_POINTS-1], '0);
         send_item(REQ_QUERY, '0, X_LOWEST, '0);
         send_item(REQ_QUERY, '0, X_HIGHEST, '0);
      end
   endtask

   task automatic run_random_phase(input int idle_pct, input int item_goal);
      int sent;
      int n;
      int queries;
      int pick;
      logic [COUNT_W-1:0] raw_count;
      logic [COUNT_W-1:0] extremes [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd65, 7'd127};
      sender_idle_pct = idle_pct;
      sent = 0;
      while (sent < item_goal) begin
         pick = $urandom_range(99);
         if (pick < 8) raw_count = extremes[$urandom_range(5)];
         else if (pick < 70) raw_count = COUNT_W'($urandom_range(2, 8));
         else if (pick < 90) raw_count = COUNT_W'($urandom_range(9, 20));
         else raw_count = COUNT_W'($urandom_range(21, 64));
         write_point_count(raw_count);
         n = effective_points();
         if ($urandom_range(99) < 80) begin
            load_sorted_table(n);
            queries = $urandom_range(4, 16);
            repeat (queries)
               send_item(REQ_QUERY, ADDR_W'($urandom), pick_query_x(n), $urandom);
            sent += n + queries;
         end else begin
            repeat (12) begin
               if ($urandom_range(99) < 30)
                  send_item(REQ_WRITE, ADDR_W'($urandom), $urandom, $urandom);
               else
                  send_item(REQ_QUERY, ADDR_W'($urandom), $urandom, $urandom);
            end
            sent += 12;
         end
      end
   endtask

   task automatic test_random_tables();
      run_random_phase(38, 330);
      run_random_phase(84, 330);
      run_random_phase(0, 340);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_breakpoints();
      test_zero_span();
      test_region_clamps();
      wait_idle();
      test_point_count_limits();
      test_random_tables();
      wait_idle();
      repeat (200) @(posedge clock);
      $display("Covered %0d breakpoint writes and %0d point_count writes.",
               write_count, cfg_count);
      $display("Checked %0d queries: %0d inside, %0d below, %0d above the table.",
               region_count[0] + region_count[1] + region_count[2],
               region_count[0], region_count[1], region_count[2]);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Timeout with %0d results outstanding.", pending_interp.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
